[sv/smc_pkg.sv]
package smc_pkg;

	localparam int DataStackDepth = 64;
	localparam int ReturnStackDepth = 64;
	localparam int MemoryCells = 1024;
	localparam int CellBits = 32;

	typedef enum logic [3:0] {
		CMD_EXIT     = 4'd0,
		CMD_CALL     = 4'd1,
		CMD_LITERAL  = 4'd2,
		CMD_DUP      = 4'd3,
		CMD_SWAP     = 4'd4,
		CMD_DROP     = 4'd5,
		CMD_MINUS    = 4'd6,
		CMD_ZEQUAL   = 4'd7,
		CMD_SKIP     = 4'd8,
		CMD_ZSKIP    = 4'd9,
		CMD_VARIABLE = 4'd10,
		CMD_FETCH    = 4'd11,
		CMD_STORE    = 4'd12
	} cmd_t;

	typedef struct packed {
		logic [3:0]  command;
		logic [31:0] body_value;
		logic [31:0] inline_cell;
	} in_word_t;

	typedef struct packed {
		logic [31:0] top_value;
		logic [31:0] next_ip;
		logic        halted;
		logic [31:0] executed_count;
		logic        stack_fault;
	} out_word_t;

	// decoded command, produced by the front end
	typedef struct packed {
		logic        pop_ret;
		logic        push_ret;
		logic        push_data;
		logic        pop_data;
		logic        pop_data2;
		logic        peek_data;
		logic [3:0]  command;
		logic [31:0] body_value;
		logic [31:0] inline_cell;
	} dec_t;

endpackage

[sv/smc_ram.sv]
module smc_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/smc_front.sv]
module smc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  smc_pkg::in_word_t in_data,
	output logic              q_valid,
	input  logic              q_ready,
	output smc_pkg::dec_t     q_data
);

	// two-entry queue of decoded words
	smc_pkg::dec_t ent_q [2];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;
	smc_pkg::dec_t dec;
	logic          push, pop;

	always_comb begin
		dec = '0;
		dec.command = in_data.command;
		dec.body_value = in_data.body_value;
		dec.inline_cell = in_data.inline_cell;
		case (smc_pkg::cmd_t'(in_data.command))
			smc_pkg::CMD_EXIT:     dec.pop_ret = 1'b1;
			smc_pkg::CMD_CALL:     dec.push_ret = 1'b1;
			smc_pkg::CMD_LITERAL,
			smc_pkg::CMD_DUP,
			smc_pkg::CMD_VARIABLE: dec.push_data = 1'b1;
			smc_pkg::CMD_SWAP:     dec.peek_data = 1'b1;
			smc_pkg::CMD_DROP,
			smc_pkg::CMD_MINUS,
			smc_pkg::CMD_ZSKIP:    dec.pop_data = 1'b1;
			smc_pkg::CMD_STORE: begin
				dec.pop_data = 1'b1;
				dec.pop_data2 = 1'b1;
			end
			default: ;
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = ent_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[sv/smc_back.sv]
module smc_back #(
	parameter int DataStackDepth = smc_pkg::DataStackDepth,
	parameter int ReturnStackDepth = smc_pkg::ReturnStackDepth,
	parameter int MemoryCells = smc_pkg::MemoryCells
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  smc_pkg::dec_t      q_data,
	output logic               out_valid,
	input  logic               out_ready,
	output smc_pkg::out_word_t out_data
);

	localparam int CellBits = smc_pkg::CellBits;
	localparam int DAw = $clog2(DataStackDepth);
	localparam int RAw = $clog2(ReturnStackDepth);
	localparam int MAw = $clog2(MemoryCells);
	localparam int DDw = $clog2(DataStackDepth + 1);
	localparam int RDw = $clog2(ReturnStackDepth + 1);
	localparam int MemClr = MemoryCells > DataStackDepth ?
		(MemoryCells > ReturnStackDepth ? MemoryCells : ReturnStackDepth) :
		(DataStackDepth > ReturnStackDepth ? DataStackDepth : ReturnStackDepth);
	localparam int CAw = $clog2(MemClr + 1);

	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_READ2, ST_DONE} st_t;

	st_t                st_q;
	logic [CAw-1:0]     clr_q;
	logic [CellBits-1:0] tos_q, ip_q, a_q;
	logic [31:0]        cnt_q;
	logic [DDw-1:0]     dd_q;
	logic [RDw-1:0]     rd_q;
	logic               fault_q;
	smc_pkg::dec_t      cur_q;
	logic [CellBits-1:0] ipa_q;

	logic                ds_we, rs_we, cm_we;
	logic [DAw-1:0]      ds_wa, ds_ra;
	logic [RAw-1:0]      rs_wa, rs_ra;
	logic [MAw-1:0]      cm_wa, cm_ra;
	logic [CellBits-1:0] ds_wd, rs_wd, cm_wd, ds_rd, rs_rd, cm_rd;

	smc_ram #(.Width(CellBits), .Depth(DataStackDepth)) u_ds (
		.clk, .we(ds_we), .waddr(ds_wa), .wdata(ds_wd), .raddr(ds_ra), .rdata(ds_rd));
	smc_ram #(.Width(CellBits), .Depth(ReturnStackDepth)) u_rs (
		.clk, .we(rs_we), .waddr(rs_wa), .wdata(rs_wd), .raddr(rs_ra), .rdata(rs_rd));
	smc_ram #(.Width(CellBits), .Depth(MemoryCells)) u_cm (
		.clk, .we(cm_we), .waddr(cm_wa), .wdata(cm_wd), .raddr(cm_ra), .rdata(cm_rd));

	// pop index: depth-1, wrapping to the top slot when empty
	logic            d_empty, d_full, r_empty, r_full;
	logic [DAw-1:0]  d_top, d_under;
	logic [RAw-1:0]  r_top;
	logic [DDw-1:0]  dd_m1, dd_m2;
	logic            take;
	logic [CellBits-1:0] ip_adv;
	logic            load_out;

	assign d_empty = (dd_q == '0);
	assign d_full = (dd_q == DDw'(DataStackDepth));
	assign r_empty = (rd_q == '0);
	assign r_full = (rd_q == RDw'(ReturnStackDepth));
	assign dd_m1 = d_empty ? DDw'(DataStackDepth - 1) : dd_q - 1'b1;
	assign dd_m2 = (dd_m1 == '0) ? DDw'(DataStackDepth - 1) : dd_m1 - 1'b1;
	assign d_top = dd_m1[DAw-1:0];
	assign d_under = dd_m2[DAw-1:0];
	assign r_top = r_empty ? RAw'(ReturnStackDepth - 1) : RAw'(rd_q - 1'b1);
	assign take = q_valid && q_ready;
	assign q_ready = (st_q == ST_IDLE);
	assign ip_adv = (ip_q != '0) ? ip_q + 1'b1 : ip_q;
	// result register is free or being emptied this cycle
	assign load_out = (st_q == ST_DONE) && (!out_valid || out_ready);

	// reads for the accepted word start in idle; store's second in ST_READ
	always_comb begin
		ds_ra = (st_q == ST_READ && cur_q.pop_data2) ? d_under : d_top;
		rs_ra = r_top;
		cm_ra = MAw'(tos_q);
	end

	logic                fire;
	logic [CellBits-1:0] n_tos, n_ip;
	logic [DDw-1:0]      n_dd;
	logic [RDw-1:0]      n_rd;
	logic                n_fault;

	assign fire = (st_q == ST_READ && !cur_q.pop_data2) || st_q == ST_READ2;

	always_comb begin
		n_tos = tos_q;
		n_ip = ipa_q;
		n_dd = dd_q;
		n_rd = rd_q;
		n_fault = 1'b0;
		ds_we = 1'b0; ds_wa = '0; ds_wd = tos_q;
		rs_we = 1'b0; rs_wa = '0; rs_wd = ipa_q;
		cm_we = 1'b0; cm_wa = MAw'(tos_q); cm_wd = a_q;
		if (st_q == ST_CLEAR) begin
			ds_we = 1'b1; ds_wa = DAw'(clr_q); ds_wd = '0;
			rs_we = 1'b1; rs_wa = RAw'(clr_q); rs_wd = '0;
			cm_we = 1'b1; cm_wa = MAw'(clr_q); cm_wd = '0;
		end else if (fire) begin
			case (smc_pkg::cmd_t'(cur_q.command))
				smc_pkg::CMD_EXIT: begin
					n_fault = r_empty;
					n_ip = rs_rd;
					n_rd = RDw'(r_top);
				end
				smc_pkg::CMD_CALL: begin
					n_fault = r_full;
					rs_we = 1'b1;
					rs_wa = r_full ? '0 : RAw'(rd_q);
					n_rd = r_full ? RDw'(1) : rd_q + 1'b1;
					n_ip = cur_q.body_value[CellBits-1:0];
				end
				smc_pkg::CMD_LITERAL, smc_pkg::CMD_DUP, smc_pkg::CMD_VARIABLE: begin
					n_fault = d_full;
					ds_we = 1'b1;
					ds_wa = d_full ? '0 : DAw'(dd_q);
					n_dd = d_full ? DDw'(1) : dd_q + 1'b1;
					if (cur_q.command == smc_pkg::CMD_LITERAL) begin
						n_tos = cur_q.inline_cell[CellBits-1:0];
						n_ip = ipa_q + 1'b1;
					end else if (cur_q.command == smc_pkg::CMD_VARIABLE) begin
						n_tos = cur_q.body_value[CellBits-1:0];
					end
				end
				smc_pkg::CMD_SWAP: begin
					n_fault = d_empty;
					ds_we = 1'b1;
					ds_wa = d_top;
					n_tos = ds_rd;
				end
				smc_pkg::CMD_DROP: begin
					n_fault = d_empty;
					n_tos = ds_rd;
					n_dd = dd_m1;
				end
				smc_pkg::CMD_MINUS: begin
					n_fault = d_empty;
					n_tos = ds_rd - tos_q;
					n_dd = dd_m1;
				end
				smc_pkg::CMD_ZEQUAL: n_tos = (tos_q == '0) ? '1 : '0;
				smc_pkg::CMD_SKIP: n_ip = ipa_q + cur_q.inline_cell[CellBits-1:0] + 1'b1;
				smc_pkg::CMD_ZSKIP: begin
					n_fault = d_empty;
					n_ip = (tos_q == '0) ?
						ipa_q + cur_q.inline_cell[CellBits-1:0] + 1'b1 : ipa_q + 1'b1;
					n_tos = ds_rd;
					n_dd = dd_m1;
				end
				smc_pkg::CMD_FETCH: n_tos = cm_rd;
				smc_pkg::CMD_STORE: begin
					// second read lands now; first pop was captured in a_q
					n_fault = d_empty || (dd_m1 == '0);
					cm_we = 1'b1;
					n_tos = ds_rd;
					n_dd = dd_m2;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= q_data;
		end
		if (st_q == ST_READ) begin
			a_q <= ds_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			clr_q <= '0;
			tos_q <= '0;
			ip_q <= '0;
			ipa_q <= '0;
			cnt_q <= '0;
			dd_q <= '0;
			rd_q <= '0;
			fault_q <= 1'b0;
			out_valid <= 1'b0;
			out_data <= '0;
		end else begin
			out_valid <= load_out || (out_valid && !out_ready);
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CAw'(MemClr - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: if (take) begin
					ipa_q <= ip_adv;
					if (ip_q != '0) cnt_q <= cnt_q + 1'b1;
					st_q <= ST_READ;
				end
				ST_READ: st_q <= cur_q.pop_data2 ? ST_READ2 : ST_DONE;
				ST_READ2: st_q <= ST_DONE;
				ST_DONE: if (load_out) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
			if (fire) begin
				tos_q <= n_tos;
				ip_q <= n_ip;
				dd_q <= n_dd;
				rd_q <= n_rd;
				fault_q <= n_fault;
			end
			if (load_out) begin
				out_data.top_value <= 32'(tos_q);
				out_data.next_ip <= 32'(ip_q);
				out_data.halted <= (ip_q == '0);
				out_data.executed_count <= cnt_q;
				out_data.stack_fault <= fault_q;
			end
		end
	end

endmodule

[sv/stack_machine_core.sv]
// stack machine core: runs one threaded-code primitive per input word.
// in channel (in_valid/in_ready/in_data) carries the command, code-field
// parameter and the inline cell at ip. out channel (out_valid/out_ready/
// out_data) returns top of stack, next ip, halted, count and stack fault.
// a front end decodes words into a two-entry queue; the back end executes
// them against the data stack, return stack and cell memory rams.
// each primitive passes the read and done states in the back end (store
// also passes read2, as it reads two stack slots through one ram port);
// the single-read-port stack ram and the registered ram read set these states.
// an accepted word reaches out_valid through those states and the output
// register when the back end is free, later while earlier words queue.
// after reset the back end clears all three rams, one entry per cycle,
// over max(MEMORY_CELLS, stack depths) entries; words queue up meanwhile.
// when the receiver stalls the result holds in the output register and the
// back end waits; the front queue keeps taking words until it is full.
module stack_machine_core #(
	parameter int DATA_STACK_DEPTH = smc_pkg::DataStackDepth,
	parameter int RETURN_STACK_DEPTH = smc_pkg::ReturnStackDepth,
	parameter int MEMORY_CELLS = smc_pkg::MemoryCells
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  smc_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output smc_pkg::out_word_t out_data
);

	logic          q_valid, q_ready;
	smc_pkg::dec_t q_data;

	smc_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.q_valid, .q_ready, .q_data
	);

	smc_back #(
		.DataStackDepth(DATA_STACK_DEPTH),
		.ReturnStackDepth(RETURN_STACK_DEPTH),
		.MemoryCells(MEMORY_CELLS)
	) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_data,
		.out_valid, .out_ready, .out_data
	);

endmodule

[verif/tb_stack_machine_core.sv]
`timescale 1ns / 1ps

module tb_stack_machine_core;

	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_WORDS = 460;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	smc_pkg::in_word_t in_data;
	logic out_valid;
	logic out_ready;
	smc_pkg::out_word_t out_data;

	stack_machine_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// machine shadow state
	logic [31:0] m_top;
	logic [31:0] m_ip;
	logic [31:0] m_dstack [smc_pkg::DataStackDepth];
	int m_ddepth;
	logic [31:0] m_rstack [smc_pkg::ReturnStackDepth];
	int m_rdepth;
	logic [31:0] m_mem [smc_pkg::MemoryCells];
	logic [31:0] m_count;
	logic m_fault;

	smc_pkg::out_word_t pending_results[$];
	int mismatches;
	int cycles;
	bit hold_off;
	bit calm;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic void machine_reset();
		m_top = '0;
		m_ip = '0;
		m_ddepth = 0;
		m_rdepth = 0;
		m_count = '0;
		foreach (m_dstack[i]) m_dstack[i] = '0;
		foreach (m_rstack[i]) m_rstack[i] = '0;
		foreach (m_mem[i]) m_mem[i] = '0;
	endfunction

	function automatic void push_data(logic [31:0] v);
		if (m_ddepth >= smc_pkg::DataStackDepth) begin
			m_fault = 1'b1;
			m_ddepth = 0;
		end
		m_dstack[m_ddepth] = v;
		m_ddepth++;
	endfunction

	function automatic logic [31:0] pop_data();
		if (m_ddepth == 0) begin
			m_fault = 1'b1;
			m_ddepth = smc_pkg::DataStackDepth;
		end
		m_ddepth--;
		return m_dstack[m_ddepth];
	endfunction

	function automatic void push_ret(logic [31:0] v);
		if (m_rdepth >= smc_pkg::ReturnStackDepth) begin
			m_fault = 1'b1;
			m_rdepth = 0;
		end
		m_rstack[m_rdepth] = v;
		m_rdepth++;
	endfunction

	function automatic logic [31:0] pop_ret();
		if (m_rdepth == 0) begin
			m_fault = 1'b1;
			m_rdepth = smc_pkg::ReturnStackDepth;
		end
		m_rdepth--;
		return m_rstack[m_rdepth];
	endfunction

	function automatic smc_pkg::out_word_t execute_primitive(smc_pkg::in_word_t w);
		smc_pkg::out_word_t r;
		logic [31:0] tos;
		logic [31:0] ip;
		logic [31:0] a;
		int k;
		tos = m_top;
		ip = m_ip;
		m_fault = 1'b0;
		if (ip != 0) begin
			ip = ip + 1;
			m_count = m_count + 1;
		end
		case (w.command)
			smc_pkg::CMD_EXIT: ip = pop_ret();
			smc_pkg::CMD_CALL: begin
				push_ret(ip);
				ip = w.body_value;
			end
			smc_pkg::CMD_LITERAL: begin
				push_data(tos);
				tos = w.inline_cell;
				ip = ip + 1;
			end
			smc_pkg::CMD_DUP: push_data(tos);
			smc_pkg::CMD_SWAP: begin
				if (m_ddepth == 0) begin
					m_fault = 1'b1;
					k = smc_pkg::DataStackDepth - 1;
				end else begin
					k = m_ddepth - 1;
				end
				a = m_dstack[k];
				m_dstack[k] = tos;
				tos = a;
			end
			smc_pkg::CMD_DROP: tos = pop_data();
			smc_pkg::CMD_MINUS: begin
				a = pop_data();
				tos = a - tos;
			end
			smc_pkg::CMD_ZEQUAL: tos = (tos == 0) ? 32'hFFFF_FFFF : 32'h0;
			smc_pkg::CMD_SKIP: ip = ip + w.inline_cell + 1;
			smc_pkg::CMD_ZSKIP: begin
				ip = (tos == 0) ? ip + w.inline_cell + 1 : ip + 1;
				tos = pop_data();
			end
			smc_pkg::CMD_VARIABLE: begin
				push_data(tos);
				tos = w.body_value;
			end
			smc_pkg::CMD_FETCH: tos = m_mem[tos % smc_pkg::MemoryCells];
			smc_pkg::CMD_STORE: begin
				a = pop_data();
				m_mem[tos % smc_pkg::MemoryCells] = a;
				tos = pop_data();
			end
			default: ;
		endcase
		m_top = tos;
		m_ip = ip;
		r.top_value = tos;
		r.next_ip = ip;
		r.halted = (ip == 0);
		r.executed_count = m_count;
		r.stack_fault = m_fault;
		return r;
	endfunction

	// directed table: given expectation checked on top of the predictor
	typedef struct {
		smc_pkg::in_word_t w;
		bit has_fixed;
		smc_pkg::out_word_t fixed;
	} dir_row_t;

	dir_row_t dir_rows[$];

	function automatic smc_pkg::in_word_t mk(logic [3:0] c, logic [31:0] b, logic [31:0] i);
		smc_pkg::in_word_t w;
		w.command = c;
		w.body_value = b;
		w.inline_cell = i;
		return w;
	endfunction

	function automatic void add_row(smc_pkg::in_word_t w, bit fx = 0, logic [31:0] t = 0,
			logic [31:0] ip = 0, logic h = 0, logic [31:0] n = 0, logic f = 0);
		dir_row_t d;
		d.w = w;
		d.has_fixed = fx;
		d.fixed = '{t, ip, h, n, f};
		dir_rows.push_back(d);
	endfunction

	task automatic send_word(smc_pkg::in_word_t w);
		smc_pkg::out_word_t e;
		while (!calm && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		e = execute_primitive(w);
		pending_results.push_back(e);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic smc_pkg::in_word_t random_word();
		smc_pkg::in_word_t w;
		int r;
		w.body_value = $urandom();
		w.inline_cell = $urandom();
		r = $urandom_range(99);
		if (r < 85) begin
			w.command = smc_pkg::cmd_t'($urandom_range(smc_pkg::CMD_STORE, smc_pkg::CMD_EXIT));
			// keep ip in a sane range most of the time so skip and call stay readable
			if ($urandom_range(3) != 0) w.inline_cell = $urandom_range(20);
			if ($urandom_range(3) != 0) w.body_value = $urandom_range(2047);
		end else begin
			w.command = 4'($urandom_range(15));
		end
		// stay away from deep wrap most of the time
		if (w.command == smc_pkg::CMD_CALL && m_rdepth > 40 && $urandom_range(3) != 0)
			w.command = smc_pkg::CMD_EXIT;
		if ((w.command == smc_pkg::CMD_DUP || w.command == smc_pkg::CMD_LITERAL ||
				w.command == smc_pkg::CMD_VARIABLE) && m_ddepth > 40 &&
				$urandom_range(3) != 0)
			w.command = smc_pkg::CMD_DROP;
		return w;
	endfunction

	// result checker
	always @(posedge clk) begin
		smc_pkg::out_word_t e;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word %h", out_data);
			end else begin
				e = pending_results.pop_front();
				if (out_data !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp top %h ip %h h %b n %h f %b, %s",
							e.top_value, e.next_ip, e.halted, e.executed_count,
							e.stack_fault,
							$sformatf("got top %h ip %h h %b n %h f %b",
								out_data.top_value, out_data.next_ip,
								out_data.halted, out_data.executed_count,
								out_data.stack_fault));
				end
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (hold_off)
			out_ready <= 1'b0;
		else if (calm)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(99) >= 34);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_stack_machine_core: done, errors");
			$finish;
		end
	end

	initial begin
		smc_pkg::out_word_t e;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		mismatches = 0;
		cycles = 0;
		hold_off = 0;
		calm = 0;
		machine_reset();

		// entry from halt: ip stays zero, count stays zero
		add_row(mk(smc_pkg::CMD_DUP, 0, 0), 1, 0, 0, 1, 0, 0);
		add_row(mk(smc_pkg::CMD_DROP, 0, 0), 1, 0, 0, 1, 0, 0);
		// pop from an empty stack faults
		add_row(mk(smc_pkg::CMD_DROP, 0, 0), 1, 0, 0, 1, 0, 1);
		add_row(mk(smc_pkg::CMD_SWAP, 0, 0));
		add_row(mk(smc_pkg::CMD_EXIT, 0, 0), 1, 0, 0, 1, 0, 1);
		add_row(mk(smc_pkg::CMD_CALL, 32'hFFFF_FFFF, 0), 1, 0, 32'hFFFF_FFFF, 0, 0, 0);
		add_row(mk(smc_pkg::CMD_LITERAL, 0, 32'hFFFF_FFFF));
		add_row(mk(smc_pkg::CMD_LITERAL, 0, 32'h8000_0001));
		add_row(mk(smc_pkg::CMD_MINUS, 0, 0));
		add_row(mk(smc_pkg::CMD_ZEQUAL, 0, 0));
		add_row(mk(smc_pkg::CMD_ZEQUAL, 0, 0));
		add_row(mk(smc_pkg::CMD_VARIABLE, 32'd1023, 0));
		add_row(mk(smc_pkg::CMD_LITERAL, 0, 32'h1234_5678));
		add_row(mk(smc_pkg::CMD_SWAP, 0, 0));
		add_row(mk(smc_pkg::CMD_STORE, 0, 0));
		add_row(mk(smc_pkg::CMD_VARIABLE, 32'hFFFF_FBFF, 0));
		add_row(mk(smc_pkg::CMD_FETCH, 0, 0));
		add_row(mk(smc_pkg::CMD_SKIP, 0, 32'hFFFF_FFFF));
		add_row(mk(smc_pkg::CMD_ZSKIP, 0, 32'd5));
		add_row(mk(smc_pkg::CMD_ZSKIP, 0, 32'd5));
		add_row(mk(4'd13, 0, 0));
		add_row(mk(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		add_row(mk(smc_pkg::CMD_CALL, 0, 0));
		add_row(mk(smc_pkg::CMD_EXIT, 0, 0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			e = execute_primitive(dir_rows[i].w);
			if (dir_rows[i].has_fixed && e !== dir_rows[i].fixed) begin
				mismatches++;
				if (mismatches <= 10)
					$display("table row %0d: fixed %h, predicted %h", i, dir_rows[i].fixed, e);
			end
		end
		// send_word predicts again from a fresh shadow state
		machine_reset();
		foreach (dir_rows[i]) send_word(dir_rows[i].w);

		// receiver holds off while the sender keeps offering
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 30; i++) send_word(random_word());
		join
		wait_drain();

		// overflow both stacks with calm handshakes
		calm = 1;
		send_word(mk(smc_pkg::CMD_CALL, 32'd100, 0));
		for (int i = 0; i < smc_pkg::DataStackDepth + 2; i++)
			send_word(mk(smc_pkg::CMD_DUP, 0, 0));
		for (int i = 0; i < smc_pkg::ReturnStackDepth + 2; i++)
			send_word(mk(smc_pkg::CMD_CALL, i + 7, 0));
		calm = 0;

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			calm = (i >= 200 && i < 300);
			send_word(random_word());
		end
		calm = 0;

		wait_drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb_stack_machine_core: done, clean");
		else
			$display("tb_stack_machine_core: done, errors");
		$finish;
	end

endmodule

[filelist.f]
sv/smc_pkg.sv
sv/smc_ram.sv
sv/smc_front.sv
sv/smc_back.sv
sv/stack_machine_core.sv
verif/tb_stack_machine_core.sv
